// ===== design/psdf_pkg.sv =====
// ----------------------------------------------------------------------------
// psdf_pkg : shared types and constants for the primitive distance core
// Widths, register indexes and the per-cell square root step.
// ----------------------------------------------------------------------------
package psdf_pkg;

    localparam int CoordW = 32;
    localparam int RadW   = 31;
    localparam int SumW   = 66;
    localparam int RootW  = 33;
    localparam int SqSteps = 33;

    localparam logic [1:0] REG_SHAPE = 2'd0;
    localparam logic [1:0] REG_MAJOR = 2'd1;
    localparam logic [1:0] REG_MINOR = 2'd2;

    typedef struct packed {
        logic [SumW-1:0]  rem;
        logic [RootW-1:0] root;
    } sq_state_t;

    typedef struct packed {
        logic                    shape;
        logic [RadW-1:0]         major;
        logic [RadW-1:0]         minor;
        logic signed [CoordW:0]  ay;
    } side_t;

    // one restoring square root step on bit pair k (k counted from the least significant pair)
    function automatic sq_state_t sq_step(input sq_state_t s, input int k);
        sq_state_t       r;
        logic [SumW-1:0] rem2;
        logic [SumW-1:0] trial;
        begin
            rem2  = s.rem;
            trial = ({{(SumW-RootW-2){1'b0}}, s.root, 2'b01}) << (2 * k);
            if (rem2 >= trial) begin
                r.rem  = rem2 - trial;
                r.root = {s.root[RootW-2:0], 1'b1};
            end else begin
                r.rem  = rem2;
                r.root = {s.root[RootW-2:0], 1'b0};
            end
            sq_step = r;
        end
    endfunction

endpackage

// ===== design/psdf_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// psdf_sqrt_cell : one stage of the square root chain
// Resolves one root bit and hands remainder, partial root and side data on.
// ----------------------------------------------------------------------------
module psdf_sqrt_cell
    import psdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic [5:0] step,
    input  logic      vin,
    input  sq_state_t sin,
    input  side_t     din,
    output logic      vout,
    output sq_state_t sout,
    output side_t     dout
);

    logic      v_reg;
    sq_state_t s_reg;
    side_t     d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= sq_step(sin, int'(step));
            d_reg <= din;
        end
    end

    assign vout = v_reg;
    assign sout = s_reg;
    assign dout = d_reg;

endmodule

// ===== design/psdf_sqrt_chain.sv =====
// ----------------------------------------------------------------------------
// psdf_sqrt_chain : row of square root cells
// Takes a 66-bit sum and returns its truncated root, resolved by one cell per root bit.
// ----------------------------------------------------------------------------
module psdf_sqrt_chain
    import psdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vin,
    input  logic [SumW-1:0]  sum,
    input  side_t            din,
    output logic             vout,
    output logic [RootW-1:0] root,
    output side_t            dout
);

    logic      v [0:SqSteps];
    sq_state_t s [0:SqSteps];
    side_t     d [0:SqSteps];

    assign v[0]      = vin;
    assign s[0].rem  = sum;
    assign s[0].root = '0;
    assign d[0]      = din;

    for (genvar i = 0; i < SqSteps; i++)
    begin : g_cell
        psdf_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .step (6'(SqSteps - 1 - i)),
            .vin  (v[i]),
            .sin  (s[i]),
            .din  (d[i]),
            .vout (v[i+1]),
            .sout (s[i+1]),
            .dout (d[i+1])
        );
    end

    assign vout = v[SqSteps];
    assign root = s[SqSteps].root;
    assign dout = d[SqSteps];

endmodule

// ===== design/primitive_sdf_eval_core.sv =====
// ----------------------------------------------------------------------------
// primitive_sdf_eval_core : signed distance to a sphere or a y-axis torus
// Streaming point in, distance and saturation flag out.
// ----------------------------------------------------------------------------
// One point is taken every cycle while the output is empty or the result side
// is ready. From input transfer to result transfer a point passes through
// magnitudes, squares and first sum, a row of 33 square root cells (one root
// bit per cell), ring offset and second sum, a second row of 33 cells, then
// radius subtraction and clamp. For the sphere the second row takes the square
// of the first root and hands the same root on. A result waiting at the output
// holds the whole pipeline and the input. Radii and shape are sampled with
// each point as it enters.
module primitive_sdf_eval_core
    import psdf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // px, py, pz
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // distance
    output logic         m_axis_tuser   // saturated
);

    logic            shape_reg;
    logic [RadW-1:0] major_reg;
    logic [RadW-1:0] minor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= 1'b0;
            major_reg <= 31'd65536;
            minor_reg <= 31'd16384;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHAPE: shape_reg <= cfg_data[0];
                REG_MAJOR: major_reg <= cfg_data;
                REG_MINOR: minor_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage A: magnitudes
    logic            va_reg;
    logic [CoordW:0] ax_reg, ay_reg, az_reg;
    side_t           sa_reg;
    logic signed [CoordW-1:0] px, py, pz;
    assign px = s_axis_tdata[31:0];
    assign py = s_axis_tdata[63:32];
    assign pz = s_axis_tdata[95:64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) va_reg <= 1'b0;
        else if (en) va_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= px[CoordW-1] ? -{px[CoordW-1], px} : {1'b0, px};
            ay_reg <= py[CoordW-1] ? -{py[CoordW-1], py} : {1'b0, py};
            az_reg <= pz[CoordW-1] ? -{pz[CoordW-1], pz} : {1'b0, pz};
            sa_reg <= '{shape: shape_reg, major: major_reg, minor: minor_reg, ay: '0};
        end
    end

    // stage B: squares
    logic            vb_reg;
    logic [63:0]     xx_reg, yy_reg, zz_reg;
    side_t           sb_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vb_reg <= 1'b0;
        else if (en) vb_reg <= va_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= 64'(ax_reg * ax_reg);
            yy_reg <= 64'(ay_reg * ay_reg);
            zz_reg <= 64'(az_reg * az_reg);
            sb_reg <= '{shape: sa_reg.shape, major: sa_reg.major, minor: sa_reg.minor,
                        ay: ay_reg};
        end
    end

    // stage C: first sum
    logic            vc_reg;
    logic [SumW-1:0] s1_reg;
    side_t           sc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vc_reg <= 1'b0;
        else if (en) vc_reg <= vb_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= SumW'(xx_reg) + SumW'(zz_reg)
                        + (sb_reg.shape ? '0 : SumW'(yy_reg));
            sc_reg   <= sb_reg;
        end
    end

    // y magnitude rides along in side data; its square is recomputed later
    logic             v1;
    logic [RootW-1:0] r1;
    side_t            d1;
    psdf_sqrt_chain u_sqrt1 (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(vc_reg), .sum(s1_reg),
        .din(sc_reg), .vout(v1), .root(r1), .dout(d1)
    );

    // stage D: q = root - R for the torus, root itself for the sphere
    logic                   vd_reg;
    logic signed [RootW+1:0] q_reg;
    side_t                  sd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vd_reg <= 1'b0;
        else if (en) vd_reg <= v1;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg  <= d1.shape ? $signed({2'b00, r1}) - $signed({4'b0000, d1.major})
                               : $signed({2'b00, r1});
            sd_reg <= d1;
        end
    end

    // stage E: second sum (sphere squares the first root alone)
    logic            ve_reg;
    logic [SumW-1:0] s2_reg;
    side_t           se_reg;
    logic [RootW-1:0] aq;
    assign aq = q_reg[RootW+1] ? RootW'(-q_reg) : RootW'(q_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ve_reg <= 1'b0;
        else if (en) ve_reg <= vd_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg  <= SumW'(aq * aq)
                       + (sd_reg.shape ? SumW'(sd_reg.ay * sd_reg.ay) : '0);
            se_reg  <= sd_reg;
        end
    end

    logic             v2;
    logic [RootW-1:0] r2;
    side_t            d2;
    psdf_sqrt_chain u_sqrt2 (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(ve_reg), .sum(s2_reg),
        .din(se_reg), .vout(v2), .root(r2), .dout(d2)
    );

    // stage G: subtract radius, saturate
    logic signed [RootW+1:0] dd;
    logic [30:0]             rad;
    assign rad = d2.shape ? d2.minor : d2.major;
    assign dd  = $signed({2'b00, r2}) - $signed({4'b0000, rad});

    logic [31:0] dist_reg;
    logic        sat_reg;
    logic        vout_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vout_reg <= 1'b0;
        else if (en) vout_reg <= v2;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dd > $signed(35'h07FFFFFFF))
            begin
                dist_reg <= 32'h7FFFFFFF;
                sat_reg  <= 1'b1;
            end
            else if (dd < -$signed(35'h080000000))
            begin
                dist_reg <= 32'h80000000;
                sat_reg  <= 1'b1;
            end
            else
            begin
                dist_reg <= dd[31:0];
                sat_reg  <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = vout_reg;
    assign m_axis_tdata  = dist_reg;
    assign m_axis_tuser  = sat_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_sat_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
        m_axis_tdata == 32'h7FFFFFFF || m_axis_tdata == 32'h80000000)
        else $error("saturation flag without clamped value");

endmodule
